FILE: sv/bie_pkg.sv
// Shared types and constants for the boolean infix evaluator.
// No dependencies; imported by the interfaces and the top level.
package bie_pkg;

    // Operator stack codes; the code value doubles as the precedence.
    typedef enum logic [1:0] {
        OP_LPAR = 2'd0,
        OP_OR   = 2'd1,
        OP_AND  = 2'd2,
        OP_NOT  = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_UNKNOWN   = 2'd1,
        ST_OVERFLOW  = 2'd2,
        ST_MALFORMED = 2'd3
    } t_status;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_LPAR  = 8'h28;
    localparam logic [7:0] CH_RPAR  = 8'h29;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_ONE   = 8'h31;
    localparam logic [7:0] CH_A     = 8'h61;
    localparam logic [7:0] CH_Z     = 8'h7A;
    localparam logic [7:0] CH_AND   = 8'h26;
    localparam logic [7:0] CH_OR    = 8'h7C;
    localparam logic [7:0] CH_NOT   = 8'h7E;

    function automatic logic [1:0] prec(input t_op op);
        logic [1:0] p;
        case (op)
            OP_OR:   p = 2'd1;
            OP_AND:  p = 2'd2;
            OP_NOT:  p = 2'd3;
            default: p = 2'd0;
        endcase
        return p;
    endfunction

endpackage

FILE: sv/bie_if.sv
// Valid/ready channel interfaces for the evaluator's input and result.
// Depends on bie_pkg.
interface bie_in_if import bie_pkg::*; ();
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       var_value;
    logic       last_char;

    modport source (output valid, char_code, var_value, last_char, input ready);
    modport sink   (input valid, char_code, var_value, last_char, output ready);
endinterface

interface bie_out_if import bie_pkg::*; ();
    logic       valid;
    logic       ready;
    logic       truth;
    logic [1:0] status;

    modport source (output valid, truth, status, input ready);
    modport sink   (input valid, truth, status, output ready);
endinterface

FILE: sv/boolean_infix_evaluator.sv
// Steps: a plain character is taken directly; each reduction is a loop check, a RAM read and a write.
// '&'/'|' add a push, ')' adds the '(' pop and the stack-top reload.
// The last character then drains: one reduction per pending operator, then close and post.
// Throughput: one character at a time; input stalls during reductions and while a result waits.
// Reset (synchronous, active low) empties both stacks, clears the error latch and the
// output valid flag; stack RAM contents are not cleared.
module boolean_infix_evaluator import bie_pkg::*; #(
    parameter int STACK_DEPTH = 64
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    bie_in_if.sink    i_in,
    bie_out_if.source o_out
);

    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam int AW = $clog2(STACK_DEPTH);
    localparam logic [CW-1:0] DEPTH_C = CW'(STACK_DEPTH);

    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_RPAR   = 8'b0000_0010,
        S_POPW   = 8'b0000_0100,
        S_OPLOOP = 8'b0000_1000,
        S_RED    = 8'b0001_0000,
        S_RED2   = 8'b0010_0000,
        S_DRAIN  = 8'b0100_0000,
        S_FIN    = 8'b1000_0000
    } t_state;

    t_state          r_state, n_state;
    t_state          r_ret, n_ret;
    logic [CW-1:0]   r_ot, n_ot;
    logic [CW-1:0]   r_bt, n_bt;
    t_op             r_opc, n_opc;      // cached top of operator stack
    logic            r_b0, n_b0;        // cached top of operand stack
    t_status         r_err, n_err;
    logic            r_last, n_last;
    t_op             r_pend, n_pend;
    t_op             r_red_op, n_red_op;
    logic            r_out_valid, n_out_valid;
    logic            r_truth, n_truth;
    t_status         r_status, n_status;

    logic            op_we, bit_we;
    logic [AW-1:0]   op_waddr, op_raddr, bit_waddr, bit_raddr;
    logic [1:0]      op_wdata, op_rd;
    logic            bit_wdata, bit_rd;

    logic            push_op_req, push_bit_req;
    t_op             push_op_val;
    logic            push_bit_val;
    logic            res;
    t_status         fin_status;
    t_state          after_state;

    logic [CW-1:0]   ot_m1, ot_m2, bt_m1, bt_m2;

    assign ot_m1 = r_ot - CW'(1);
    assign ot_m2 = r_ot - CW'(2);
    assign bt_m1 = r_bt - CW'(1);
    assign bt_m2 = r_bt - CW'(2);
    assign after_state = r_last ? S_DRAIN : S_IDLE;

    bie_ram #(.WIDTH(2), .DEPTH(STACK_DEPTH)) u_op_ram (
        .i_clk   (i_clk),
        .i_we    (op_we),
        .i_waddr (op_waddr),
        .i_wdata (op_wdata),
        .i_raddr (op_raddr),
        .o_rdata (op_rd)
    );

    bie_ram #(.WIDTH(1), .DEPTH(STACK_DEPTH)) u_bit_ram (
        .i_clk   (i_clk),
        .i_we    (bit_we),
        .i_waddr (bit_waddr),
        .i_wdata (bit_wdata),
        .i_raddr (bit_raddr),
        .o_rdata (bit_rd)
    );

    always_comb begin
        n_state      = r_state;
        n_ret        = r_ret;
        n_ot         = r_ot;
        n_bt         = r_bt;
        n_opc        = r_opc;
        n_b0         = r_b0;
        n_err        = r_err;
        n_last       = r_last;
        n_pend       = r_pend;
        n_red_op     = r_red_op;
        n_out_valid  = r_out_valid && !o_out.ready;
        n_truth      = r_truth;
        n_status     = r_status;
        op_we        = 1'b0;
        op_waddr     = r_ot[AW-1:0];
        op_wdata     = 2'(OP_LPAR);
        op_raddr     = ot_m2[AW-1:0];
        bit_we       = 1'b0;
        bit_waddr    = r_bt[AW-1:0];
        bit_wdata    = 1'b0;
        bit_raddr    = bt_m2[AW-1:0];
        push_op_req  = 1'b0;
        push_op_val  = OP_LPAR;
        push_bit_req = 1'b0;
        push_bit_val = 1'b0;
        res          = 1'b0;
        fin_status   = r_err;

        unique case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    n_last  = i_in.last_char;
                    n_state = i_in.last_char ? S_DRAIN : S_IDLE;
                    if (r_err == ST_OK) begin
                        case (i_in.char_code) inside
                            CH_SPACE: ;
                            CH_LPAR: begin
                                push_op_req = 1'b1;
                                push_op_val = OP_LPAR;
                            end
                            CH_RPAR: n_state = S_RPAR;
                            CH_ZERO, CH_ONE: begin
                                push_bit_req = 1'b1;
                                push_bit_val = i_in.char_code[0];
                            end
                            [CH_A:CH_Z]: begin
                                push_bit_req = 1'b1;
                                push_bit_val = i_in.var_value;
                            end
                            CH_NOT: begin
                                push_op_req = 1'b1;
                                push_op_val = OP_NOT;
                            end
                            CH_AND, CH_OR: begin
                                n_pend  = (i_in.char_code == CH_OR) ? OP_OR : OP_AND;
                                n_state = S_OPLOOP;
                            end
                            default: n_err = ST_UNKNOWN;
                        endcase
                    end
                end
            end
            S_RPAR: begin
                if (r_err != ST_OK) begin
                    n_state = after_state;
                end else if (r_ot == '0) begin
                    n_err   = ST_MALFORMED;
                    n_state = after_state;
                end else if (r_opc == OP_LPAR) begin
                    n_ot    = ot_m1;
                    n_state = S_POPW;
                end else begin
                    n_ret   = S_RPAR;
                    n_state = S_RED;
                end
            end
            S_POPW: begin
                n_opc   = t_op'(op_rd);
                n_state = after_state;
            end
            S_OPLOOP: begin
                if (r_err != ST_OK) begin
                    n_state = after_state;
                end else if (r_ot != '0 && r_opc != OP_LPAR &&
                             prec(r_pend) <= prec(r_opc)) begin
                    n_ret   = S_OPLOOP;
                    n_state = S_RED;
                end else begin
                    push_op_req = 1'b1;
                    push_op_val = r_pend;
                    n_state     = after_state;
                end
            end
            S_RED: begin
                // fetch the new operator top and the second operand
                if (r_ot == '0 || r_opc == OP_LPAR ||
                    (r_opc == OP_NOT && r_bt == '0) ||
                    (r_opc != OP_NOT && r_bt < CW'(2))) begin
                    if (r_err == ST_OK) begin
                        n_err = ST_MALFORMED;
                    end
                    n_state = r_ret;
                end else begin
                    n_red_op = r_opc;
                    n_state  = S_RED2;
                end
            end
            S_RED2: begin
                n_opc = t_op'(op_rd);
                n_ot  = ot_m1;
                if (r_red_op == OP_NOT) begin
                    res       = ~r_b0;
                    bit_waddr = bt_m1[AW-1:0];
                end else begin
                    res       = (r_red_op == OP_OR) ? (bit_rd | r_b0) : (bit_rd & r_b0);
                    bit_waddr = bt_m2[AW-1:0];
                    n_bt      = bt_m1;
                end
                bit_we    = 1'b1;
                bit_wdata = res;
                n_b0      = res;
                n_state   = r_ret;
            end
            S_DRAIN: begin
                if (r_err != ST_OK || r_ot == '0) begin
                    n_state = S_FIN;
                end else begin
                    n_ret   = S_DRAIN;
                    n_state = S_RED;
                end
            end
            S_FIN: begin
                if (!r_out_valid || o_out.ready) begin
                    if (r_err == ST_OK && r_bt != CW'(1)) begin
                        fin_status = ST_MALFORMED;
                    end
                    n_status    = fin_status;
                    n_truth     = (fin_status == ST_OK) ? r_b0 : 1'b0;
                    n_out_valid = 1'b1;
                    n_ot        = '0;
                    n_bt        = '0;
                    n_err       = ST_OK;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase

        if (push_op_req) begin
            if (r_ot >= DEPTH_C) begin
                n_err = ST_OVERFLOW;
            end else begin
                op_we    = 1'b1;
                op_wdata = 2'(push_op_val);
                n_opc    = push_op_val;
                n_ot     = r_ot + CW'(1);
            end
        end
        if (push_bit_req) begin
            if (r_bt >= DEPTH_C) begin
                n_err = ST_OVERFLOW;
            end else begin
                bit_we    = 1'b1;
                bit_wdata = push_bit_val;
                n_b0      = push_bit_val;
                n_bt      = r_bt + CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_ot        <= '0;
            r_bt        <= '0;
            r_err       <= ST_OK;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_ot        <= n_ot;
            r_bt        <= n_bt;
            r_err       <= n_err;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ret    <= n_ret;
        r_opc    <= n_opc;
        r_b0     <= n_b0;
        r_last   <= n_last;
        r_pend   <= n_pend;
        r_red_op <= n_red_op;
        r_truth  <= n_truth;
        r_status <= n_status;
    end

    assign i_in.ready   = (r_state == S_IDLE);
    assign o_out.valid  = r_out_valid;
    assign o_out.truth  = r_truth;
    assign o_out.status = r_status;

    a_depth_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ot <= DEPTH_C && r_bt <= DEPTH_C)
        else $error("stack count beyond depth");

    a_clear_after_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN && (!r_out_valid || o_out.ready)) |=>
            (r_ot == '0 && r_bt == '0 && r_err == ST_OK && r_out_valid))
        else $error("stacks not cleared after result");

    a_error_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_err != ST_OK && r_state != S_FIN) |=> $stable(r_err))
        else $error("error latch changed before result");

    a_truth_on_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.status != ST_OK) |-> !o_out.truth)
        else $error("nonzero truth with error status");

endmodule

FILE: sv/bie_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bie_ram #(
    parameter int  WIDTH = 1,
    parameter int  DEPTH = 64,
    localparam int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: dv/boolean_infix_evaluator_tb.sv
// Self-checking testbench for boolean_infix_evaluator: streams expressions one character
// per transaction and checks each posted result against an in-bench stack predictor.
// Depends on bie_pkg and the bie_in_if / bie_out_if interfaces.
`timescale 1ns / 100ps

module boolean_infix_evaluator_tb;
    import bie_pkg::*;

    localparam int STACK_DEPTH  = 64;
    localparam int LIMIT_CYCLES = 400000;
    localparam int CALM_ITEMS   = 250;
    localparam int RANDOM_ITEMS = 1700;
    localparam int LONG_HOLD    = 400;

    typedef struct packed {
        logic [7:0] ch;
        logic       vb;
        logic       last;
        logic       hold;   // wait for all results before offering
    } t_char_item;

    typedef struct packed {
        logic    truth;
        t_status status;
    } t_verdict;

    logic i_clk = 1'b0;
    logic i_rst_n;

    bie_in_if  in_if ();
    bie_out_if out_if ();

    boolean_infix_evaluator #(.STACK_DEPTH(STACK_DEPTH)) u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // ---------------------------------------------------------------- predictor
    t_op     op_stk  [STACK_DEPTH];
    logic    val_stk [STACK_DEPTH];
    int      op_cnt  = 0;
    int      val_cnt = 0;
    t_status err     = ST_OK;

    t_verdict   expected_results [$];
    t_char_item pending_chars    [$];
    logic [7:0] expr_buf         [$];

    function automatic void note_err(t_status s);
        if (err == ST_OK)
            err = s;
    endfunction

    function automatic void push_op(t_op op);
        if (op_cnt >= STACK_DEPTH) begin
            note_err(ST_OVERFLOW);
            return;
        end
        op_stk[op_cnt] = op;
        op_cnt++;
    endfunction

    function automatic void push_val(logic b);
        if (val_cnt >= STACK_DEPTH) begin
            note_err(ST_OVERFLOW);
            return;
        end
        val_stk[val_cnt] = b;
        val_cnt++;
    endfunction

    function automatic int rank(t_op op);
        int r;
        case (op)
            OP_OR:   r = 1;
            OP_AND:  r = 2;
            OP_NOT:  r = 3;
            default: r = 0;
        endcase
        return r;
    endfunction

    // Apply the top operator to the operand stack.
    function automatic void fold_top();
        t_op  op;
        logic a;
        logic b;
        if (op_cnt == 0 || op_stk[op_cnt-1] == OP_LPAR) begin
            note_err(ST_MALFORMED);
            return;
        end
        op = op_stk[op_cnt-1];
        op_cnt--;
        if (op == OP_NOT) begin
            if (val_cnt < 1) begin
                note_err(ST_MALFORMED);
                return;
            end
            val_stk[val_cnt-1] = ~val_stk[val_cnt-1];
            return;
        end
        if (val_cnt < 2) begin
            note_err(ST_MALFORMED);
            return;
        end
        b = val_stk[val_cnt-1];
        a = val_stk[val_cnt-2];
        val_cnt -= 2;
        push_val((op == OP_OR) ? (a | b) : (a & b));
    endfunction

    function automatic void take_char(logic [7:0] c, logic vb);
        t_op op;
        if (c == CH_SPACE) begin
            return;
        end else if (c == CH_LPAR) begin
            push_op(OP_LPAR);
        end else if (c == CH_RPAR) begin
            while (err == ST_OK) begin
                if (op_cnt == 0) begin
                    note_err(ST_MALFORMED);
                    break;
                end
                if (op_stk[op_cnt-1] == OP_LPAR) begin
                    op_cnt--;
                    break;
                end
                fold_top();
            end
        end else if (c == CH_ZERO || c == CH_ONE) begin
            push_val(c == CH_ONE);
        end else if (c >= CH_A && c <= CH_Z) begin
            push_val(vb);
        end else if (c == CH_NOT) begin
            push_op(OP_NOT);
        end else if (c == CH_AND || c == CH_OR) begin
            op = (c == CH_OR) ? OP_OR : OP_AND;
            while (err == ST_OK && op_cnt > 0 && op_stk[op_cnt-1] != OP_LPAR &&
                   rank(op) <= rank(op_stk[op_cnt-1]))
                fold_top();
            if (err == ST_OK)
                push_op(op);
        end else begin
            note_err(ST_UNKNOWN);
        end
    endfunction

    function automatic void predict_char(t_char_item it);
        t_verdict v;
        if (err == ST_OK)
            take_char(it.ch, it.vb);
        if (!it.last)
            return;
        while (err == ST_OK && op_cnt > 0)
            fold_top();
        if (err == ST_OK && val_cnt != 1)
            note_err(ST_MALFORMED);
        v.truth  = (err == ST_OK) ? val_stk[0] : 1'b0;
        v.status = err;
        expected_results.push_back(v);
        op_cnt  = 0;
        val_cnt = 0;
        err     = ST_OK;
    endfunction

    // ---------------------------------------------------------------- stimulus
    function automatic void add_ch(logic [7:0] c);
        expr_buf.push_back(c);
    endfunction

    function automatic void flush_expr(bit hold);
        t_char_item it;
        if (expr_buf.size() == 0)
            expr_buf.push_back(CH_SPACE);
        for (int i = 0; i < expr_buf.size(); i++) begin
            it.ch   = expr_buf[i];
            it.vb   = 1'($urandom_range(0, 1));
            it.last = (i == expr_buf.size() - 1);
            it.hold = hold && (i == 0);
            pending_chars.push_back(it);
        end
        expr_buf.delete();
    endfunction

    function automatic void push_str(string s);
        for (int i = 0; i < s.len(); i++)
            add_ch(s[i]);
        flush_expr(1'b0);
    endfunction

    function automatic void add_operand_tail();
        if ($urandom_range(0, 1))
            add_ch($urandom_range(0, 1) ? CH_ONE : CH_ZERO);
        else
            add_ch(CH_A + 8'($urandom_range(0, 25)));
    endfunction

    function automatic void gen_well_formed();
        int depth;
        int n;
        int target;
        int r;
        bit want_operand;
        depth        = 0;
        n            = 0;
        want_operand = 1;
        target       = $urandom_range(1, 24);
        while (1) begin
            if (want_operand) begin
                r = $urandom_range(0, 9);
                if (n < target && r < 2 && depth < 6) begin
                    add_ch(CH_LPAR);
                    depth++;
                end else if (n < target && r < 4) begin
                    add_ch(CH_NOT);
                end else begin
                    add_operand_tail();
                    want_operand = 0;
                end
            end else begin
                if (n >= target && depth == 0)
                    break;
                r = $urandom_range(0, 9);
                if (depth > 0 && (r < 3 || n >= target)) begin
                    add_ch(CH_RPAR);
                    depth--;
                end else begin
                    add_ch($urandom_range(0, 1) ? CH_AND : CH_OR);
                    want_operand = 1;
                end
            end
            if ($urandom_range(0, 7) == 0)
                add_ch(CH_SPACE);
            n++;
        end
    endfunction

    function automatic logic [7:0] odd_char();
        logic [7:0] c;
        case ($urandom_range(0, 7))
            0:       c = CH_LPAR;
            1:       c = CH_RPAR;
            2:       c = CH_AND;
            3:       c = CH_OR;
            4:       c = CH_NOT;
            default: c = 8'($urandom_range(0, 255));
        endcase
        return c;
    endfunction

    function automatic void gen_expression(bit hold);
        int kind;
        int n;
        logic [7:0] c;
        kind = $urandom_range(0, 99);
        if (kind < 72) begin
            gen_well_formed();
        end else if (kind < 88) begin
            // well-formed body with one corruption
            gen_well_formed();
            case ($urandom_range(0, 2))
                0: expr_buf.delete($urandom_range(0, expr_buf.size() - 1));
                1: expr_buf.insert($urandom_range(0, expr_buf.size()), odd_char());
                default: expr_buf.push_back(odd_char());
            endcase
        end else if (kind < 96) begin
            n = $urandom_range(1, 6);
            repeat (n) add_ch(odd_char());
        end else begin
            // runs past the stack depth
            n = $urandom_range(STACK_DEPTH + 1, STACK_DEPTH + 4);
            case ($urandom_range(0, 2))
                0:       c = CH_LPAR;
                1:       c = CH_NOT;
                default: c = CH_ONE;
            endcase
            repeat (n) add_ch(c);
            add_ch(CH_ZERO);
        end
        flush_expr(hold);
    endfunction

    // ---------------------------------------------------------------- driver
    t_char_item cur_item;
    int  n_taken   = 0;
    int  calm_from = 0;
    int  idle_left = 0;
    bit  calm;

    assign calm = (n_taken >= calm_from);

    always @(posedge i_clk) begin : drv
        logic drive_v;
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
        end else begin
            if (in_if.valid && in_if.ready)
                predict_char(cur_item);
            drive_v = in_if.valid && !in_if.ready;
            if (!drive_v) begin
                if (idle_left > 0) begin
                    idle_left--;
                end else if (pending_chars.size() > 0 &&
                             !(pending_chars[0].hold && expected_results.size() > 0)) begin
                    if (!calm && $urandom_range(0, 5) == 0) begin
                        idle_left = $urandom_range(1, 9) - 1;
                    end else begin
                        cur_item = pending_chars.pop_front();
                        n_taken++;
                        drive_v = 1'b1;
                        in_if.char_code <= cur_item.ch;
                        in_if.var_value <= cur_item.vb;
                        in_if.last_char <= cur_item.last;
                    end
                end
            end
            in_if.valid <= drive_v;
        end
    end

    // ---------------------------------------------------------------- monitor
    int n_results  = 0;
    int n_errors   = 0;
    int hold_left  = 0;
    int stall_left = 0;
    bit long_hold_done = 0;

    always @(posedge i_clk) begin : mon
        logic     rdy;
        t_verdict want;
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
        end else begin
            if (out_if.valid && out_if.ready) begin
                n_results++;
                if (expected_results.size() == 0) begin
                    n_errors++;
                    if (n_errors <= 10)
                        $display("unexpected result: truth=%0d status=%0d",
                                 out_if.truth, out_if.status);
                end else begin
                    want = expected_results.pop_front();
                    if (out_if.truth !== want.truth || out_if.status !== want.status) begin
                        n_errors++;
                        if (n_errors <= 10)
                            $display("result %0d: exp truth=%0d st=%0d, got truth=%0d st=%0d",
                                     n_results, want.truth, want.status,
                                     out_if.truth, out_if.status);
                    end
                end
            end
            if (hold_left > 0) begin
                hold_left--;
                rdy = 1'b0;
            end else if (!long_hold_done && n_results == 15) begin
                // long back-pressure so the evaluator fills and stalls its input
                long_hold_done = 1;
                hold_left = LONG_HOLD - 1;
                rdy = 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                rdy = 1'b0;
            end else if (!calm && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(1, 9) - 1;
                rdy = 1'b0;
            end else begin
                rdy = 1'b1;
            end
            out_if.ready <= rdy;
        end
    end

    // ---------------------------------------------------------------- watchdog
    int cycle_cnt = 0;

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt >= LIMIT_CYCLES) begin
            $display("timeout after %0d cycles", cycle_cnt);
            $display("FAIL");
            $finish;
        end
    end

    // ---------------------------------------------------------------- sequence
    initial begin : seq
        int n_expr;
        in_if.valid     = 1'b0;
        in_if.char_code = 8'h00;
        in_if.var_value = 1'b0;
        in_if.last_char = 1'b0;
        out_if.ready    = 1'b0;
        i_rst_n         = 1'b0;

        // directed
        push_str("1");
        push_str("~0");
        push_str("a&~(b|0)");
        push_str("z|1&0");
        push_str("#");
        push_str(")");
        push_str("(1");
        push_str(" ");
        push_str("1&");
        push_str("~");
        add_ch(8'hFF);
        flush_expr(1'b0);

        // nesting right at the stack depth, then one past it
        repeat (STACK_DEPTH) add_ch(CH_LPAR);
        add_ch(CH_ONE);
        repeat (STACK_DEPTH) add_ch(CH_RPAR);
        flush_expr(1'b1);
        repeat (STACK_DEPTH) add_ch(CH_NOT);
        add_ch(CH_ZERO);
        flush_expr(1'b0);
        repeat (STACK_DEPTH + 1) add_ch(CH_LPAR);
        flush_expr(1'b0);
        repeat (STACK_DEPTH + 1) add_ch(CH_ONE);
        flush_expr(1'b1);

        n_expr = 0;
        while (pending_chars.size() < RANDOM_ITEMS) begin
            gen_expression(n_expr % 30 == 29);
            n_expr++;
        end
        calm_from = pending_chars.size() - CALM_ITEMS;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_chars.size() > 0 || in_if.valid || expected_results.size() > 0)
            @(posedge i_clk);
        repeat (300) @(posedge i_clk);

        if (expected_results.size() > 0) begin
            n_errors += expected_results.size();
            $display("%0d expected results never arrived", expected_results.size());
        end
        if (n_errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

FILE: filelist.f
sv/bie_pkg.sv
sv/bie_if.sv
sv/bie_ram.sv
sv/boolean_infix_evaluator.sv
dv/boolean_infix_evaluator_tb.sv
